// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Label, clock, active-low reset, property expression, message.
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication with the same shape.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

// ===== hw/rtl/grc_pkg.sv =====
package grc_pkg;
  localparam int unsigned OpW = 1;
  localparam logic OpWrite = 1'b0;
  localparam logic OpScan = 1'b1;
  localparam int unsigned AngW = 9;
  localparam int unsigned DistW = 9;
  localparam int unsigned PosW = 12;
  localparam int unsigned CellIdxW = 4;
  localparam int unsigned TrigW = 16;
  localparam logic [AngW-1:0] Deg360 = 9'd360;
  localparam logic [AngW-1:0] Deg90 = 9'd90;
  localparam logic [AngW-1:0] Deg180 = 9'd180;
  localparam logic [AngW-1:0] Deg270 = 9'd270;

  typedef struct packed {
    logic [OpW-1:0] operation;
    logic [CellIdxW-1:0] cell_x;
    logic [CellIdxW-1:0] cell_y;
    logic occupied;
    logic [PosW-1:0] robot_x;
    logic [PosW-1:0] robot_y;
    logic [AngW-1:0] heading;
  } cmd_t;

  typedef struct packed {
    logic [AngW-1:0] ray_angle;
    logic [DistW-1:0] distance;
    logic last;
  } res_t;

  typedef enum logic [2:0] {
    StIdle, StClear, StRayInit, StRead, StCheck, StEmit
  } state_e;

  function automatic logic [14:0] quarter_sin(input logic [6:0] k);
    logic [14:0] t [0:90];
    t = '{15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
      15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
      15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
      15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
      15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
      15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
      15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
      15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
      15'd16382, 15'd16384};
    if (k > 7'd90) begin
      return 15'd0;
    end
    return t[k];
  endfunction

  // Signed Q2.14 sine of an angle already below 360.
  function automatic logic signed [TrigW-1:0] sin_q14(input logic [AngW-1:0] d);
    logic [AngW-1:0] k;
    logic neg;
    logic [14:0] m;
    if (d <= Deg90) begin
      k = d; neg = 1'b0;
    end else if (d <= Deg180) begin
      k = Deg180 - d; neg = 1'b0;
    end else if (d <= Deg270) begin
      k = d - Deg180; neg = 1'b1;
    end else begin
      k = Deg360 - d; neg = 1'b1;
    end
    m = quarter_sin(k[6:0]);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction
endpackage

// ===== hw/rtl/grc_if.sv =====
interface grc_cmd_if;
  grc_pkg::cmd_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grc_res_if;
  grc_pkg::res_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/grc_axis.sv =====
// One axis of a ray point: accumulate trig per step, then turn the Q.14 position
// into a cell index with truncation toward zero and report range hits.
module grc_axis #(
  parameter int unsigned CellMm = 32,
  parameter int unsigned GridN = 16,
  parameter int unsigned AccW = 32,
  parameter int unsigned IdxW = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic step_i,
  input  logic [grc_pkg::PosW-1:0] base_i,
  input  logic signed [grc_pkg::TrigW-1:0] trig_i,
  output logic out_o,
  output logic [IdxW-1:0] idx_o
);
  import grc_pkg::*;
  // Whole millimetres of a ray point stay below 2**QW in magnitude.
  localparam int unsigned QW = 13;
  localparam int unsigned RecW = QW + 2;
  localparam int unsigned CellL = $clog2(CellMm);
  localparam int unsigned RecShift = QW + CellL;
  // Rounded-up reciprocal of the cell size, exact for every QW-bit dividend.
  localparam longint unsigned RecipC = ((64'd1 << RecShift) + CellMm - 1) / CellMm;
  localparam logic [RecW-1:0] Recip = RecW'(RecipC);
  logic signed [AccW-1:0] pos_q;
  logic signed [AccW-1:0] pos_d;
  logic neg;
  logic [AccW-1:0] mag;
  logic [QW-1:0] mm;
  logic [QW+RecW-1:0] prod;
  logic [QW-1:0] cell_idx;

  always_comb begin
    pos_d = pos_q;
    if (load_i) begin
      pos_d = $signed({{(AccW-PosW-14){1'b0}}, base_i, 14'd0});
    end else if (step_i) begin
      pos_d = pos_q + AccW'(trig_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Divide the magnitude, so a negative point below one cell still lands in cell 0.
  assign neg = pos_q[AccW-1];
  assign mag = neg ? $unsigned(-pos_q) : $unsigned(pos_q);
  assign mm = mag[QW+13:14];
  assign prod = {{RecW{1'b0}}, mm} * {{QW{1'b0}}, Recip};
  assign cell_idx = QW'(prod >> RecShift);
  assign out_o = neg ? (cell_idx != '0) : (cell_idx >= QW'(GridN));
  assign idx_o = neg ? '0 : IdxW'(cell_idx);
endmodule

// ===== hw/rtl/grid_ray_cast_range_scan_top.sv =====
// Ray-casting range scanner over a one-bit occupancy grid. A write word sets one
// cell and yields nothing; a scan word casts FOV rays at successive degrees from
// the heading and yields one result word per ray, last marked. After reset the
// map is cleared one entry per cycle, all 2**(XW+YW) entries of it (256 for the 16 by 16
// grid), and input is held off meanwhile. Each ray checks up to RANGE_STEPS points
// one unit step apart through one shared pair of position accumulators; each step
// is a registered map read, then a check and advance. Each ray is loaded first and
// its word emitted last, held while the result side holds ready low. A write is
// taken and input stays ready after it; input is held off for the whole scan.
`include "assert_macros.svh"
module grid_ray_cast_range_scan_top #(
  parameter int unsigned CELL_MM = 32,
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16,
  parameter int unsigned RANGE_STEPS = 512,
  parameter int unsigned FOV = 32
) (
  input logic clk_i,
  input logic rst_ni,
  grc_cmd_if.sink cmd_i,
  grc_res_if.source res_o
);
  import grc_pkg::*;
  localparam int unsigned XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int unsigned YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int unsigned MapAw = XW + YW;
  localparam int unsigned MapDepth = 1 << MapAw;
  localparam int unsigned LenW = $clog2(RANGE_STEPS);
  localparam int unsigned RayW = (FOV > 1) ? $clog2(FOV) : 1;
  localparam int unsigned AccW = 48;

  state_e state_q, state_d;
  logic map_mem [MapDepth];
  logic rd_q;
  logic map_we;
  logic [MapAw-1:0] clr_q, clr_d;
  logic [MapAw-1:0] wr_addr, rd_addr;
  logic [PosW-1:0] rx_q, ry_q;
  logic [AngW-1:0] ang_q, ang_d;
  logic [RayW-1:0] ray_q, ray_d;
  logic [LenW-1:0] len_q, len_d;
  logic [DistW-1:0] dist_q, dist_d;
  logic signed [TrigW-1:0] cos_w, sin_w;
  logic ld, stp, ox, oy, hit, done;
  logic [XW-1:0] gx;
  logic [YW-1:0] gy;
  logic [AngW:0] hsum;
  logic [AngW-1:0] cang;

  assign cmd_i.ready = (state_q == StIdle);
  wire take = cmd_i.valid && cmd_i.ready;

  // Cos is sine at angle plus 90, reduced below 360.
  assign cang = (ang_q >= Deg270) ? (ang_q - Deg270) : (ang_q + Deg90);
  assign cos_w = sin_q14(cang);
  assign sin_w = sin_q14(ang_q);

  grc_axis #(.CellMm(CELL_MM), .GridN(GRID_W), .AccW(AccW), .IdxW(XW)) u_ax (
    .clk_i, .rst_ni, .load_i(ld), .step_i(stp), .base_i(rx_q), .trig_i(cos_w),
    .out_o(ox), .idx_o(gx));
  grc_axis #(.CellMm(CELL_MM), .GridN(GRID_H), .AccW(AccW), .IdxW(YW)) u_ay (
    .clk_i, .rst_ni, .load_i(ld), .step_i(stp), .base_i(ry_q), .trig_i(sin_w),
    .out_o(oy), .idx_o(gy));

  // Map read is registered: address in StRead, data checked in StCheck.
  assign rd_addr = {gy, gx};
  assign wr_addr = {YW'(cmd_i.data.cell_y), XW'(cmd_i.data.cell_x)};
  assign map_we = take && cmd_i.data.operation == OpWrite
                  && 32'(cmd_i.data.cell_x) < GRID_W && 32'(cmd_i.data.cell_y) < GRID_H;

  assign hit = ox || oy || rd_q;
  assign done = hit || (len_q == LenW'(RANGE_STEPS - 1));
  assign ld = (state_q == StRayInit);
  assign stp = (state_q == StCheck) && !done;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:   if (clr_q == {MapAw{1'b1}}) state_d = StIdle;
      StIdle:    if (take && cmd_i.data.operation == OpScan) state_d = StRayInit;
      StRayInit: state_d = StRead;
      StRead:    state_d = StCheck;
      StCheck:   if (done) state_d = StEmit;
                 else state_d = StRead;
      StEmit: begin
        if (res_o.ready) begin
          state_d = (ray_q == RayW'(FOV - 1)) ? StIdle : StRayInit;
        end
      end
      default:   state_d = StIdle;
    endcase
  end

  // Datapath updates.
  always_comb begin
    hsum = {1'b0, cmd_i.data.heading};
    clr_d = clr_q;
    ang_d = ang_q;
    ray_d = ray_q;
    len_d = len_q;
    dist_d = dist_q;
    case (state_q)
      StClear: clr_d = clr_q + 1'b1;
      StIdle: begin
        ray_d = '0;
        // Heading is below 512, so at most one subtract of 360 suffices.
        ang_d = (hsum >= {1'b0, Deg360}) ? AngW'(hsum - {1'b0, Deg360}) : AngW'(hsum);
      end
      StRayInit: len_d = '0;
      StCheck: if (done) begin
        dist_d = (LenW > DistW && len_q > LenW'(511)) ? 9'd511 : DistW'(len_q);
      end else begin
        len_d = len_q + 1'b1;
      end
      StEmit: if (res_o.ready) begin
        ray_d = ray_q + 1'b1;
        ang_d = (ang_q == Deg360 - 9'd1) ? '0 : ang_q + 9'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      ray_q <= '0;
      len_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ray_q <= ray_d;
      len_q <= len_d;
    end
  end

  // Clear every entry after reset, then take cell writes.
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      map_mem[clr_q] <= 1'b0;
    end else if (map_we) begin
      map_mem[wr_addr] <= cmd_i.data.occupied;
    end
    rd_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
    dist_q <= dist_d;
    if (take) begin
      rx_q <= cmd_i.data.robot_x;
      ry_q <= cmd_i.data.robot_y;
    end
  end

  assign res_o.valid = (state_q == StEmit);
  assign res_o.data.ray_angle = ang_q;
  assign res_o.data.distance = dist_q;
  assign res_o.data.last = (ray_q == RayW'(FOV - 1));

  `ASSERT_IMP(a_busy_noready, clk_i, rst_ni, state_q != StIdle, !cmd_i.ready, "ready while busy")
  `ASSERT_IMP(a_ang_range, clk_i, rst_ni, res_o.valid, ang_q < Deg360, "angle out of range")
  `ASSERT_IMP(a_hold, clk_i, rst_ni, res_o.valid && !res_o.ready, ##1 res_o.valid, "result dropped")
endmodule
